@@ rtl/cvbe_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cvbe_pkg
// Shared types and constants for the variable-block-length block encoder.
// ---------------------------------------------------------------------------
package cvbe_pkg;

    // Fixed port field widths.
    localparam int COL_IN_W    = 32;
    localparam int START_OUT_W = 32;
    localparam int LEN_OUT_W   = 8;
    localparam int TDATA_OUT_W = START_OUT_W + LEN_OUT_W;

    // Parameter defaults.
    localparam int COL_BITS_DEF = 32;
    localparam int LEN_BITS_DEF = 8;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One closed block as it leaves the encoder.
    typedef struct packed {
        logic [START_OUT_W-1:0] start;
        logic [LEN_OUT_W-1:0]   len;
        logic                   row_end;
        logic                   step_last;
    } t_result;

    // Results produced by one item: count (0..2) and the two words in order.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage
`default_nettype wire

@@ rtl/csr_to_vbl_block_encoder.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// csr_to_vbl_block_encoder
// Groups runs of consecutive sparse column indices into start/length blocks.
// ---------------------------------------------------------------------------
// One column index enters per cycle while the queue has room. An item passes
// an input register, where the gap, repeat and full-block checks and the
// length update happen in one pass, and its blocks (none, one or two) go into
// a four-word result queue. The output port moves one word per cycle while
// the receiver is ready, so the sustained rate is one item per cycle while
// items close at most one block each; an item closing two blocks needs a second
// output word. The input stalls while the queue has fewer than two free words.
module csr_to_vbl_block_encoder #(
    parameter int COL_BITS = cvbe_pkg::COL_BITS_DEF,
    parameter int LEN_BITS = cvbe_pkg::LEN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [cvbe_pkg::COL_IN_W-1:0]     i_s_tdata,  // [31:0] col_index
    input  wire logic                              i_s_tlast,  // row_last
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [cvbe_pkg::TDATA_OUT_W-1:0]       o_m_tdata,  // [31:0] block_start,
                                                               // [39:32] block_len
    output logic                                   o_m_tlast,  // row_end
    output logic                                   o_m_tuser   // step_last
);

    cvbe_pkg::t_push   push;
    cvbe_pkg::t_result head;
    logic              room;

    cvbe_core #(
        .COL_BITS (COL_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_col   (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_room  (room),
        .o_ready (o_s_tready),
        .o_push  (push)
    );

    cvbe_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (head)
    );

    assign o_m_tdata = {head.len, head.start};
    assign o_m_tlast = head.row_end;
    assign o_m_tuser = head.step_last;

endmodule
`default_nettype wire

@@ rtl/cvbe_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cvbe_core
// Input register, open-block state and the single-pass blocking decision.
// ---------------------------------------------------------------------------
module cvbe_core #(
    parameter int COL_BITS = cvbe_pkg::COL_BITS_DEF,
    parameter int LEN_BITS = cvbe_pkg::LEN_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [cvbe_pkg::COL_IN_W-1:0] i_col,
    input  wire logic                          i_last,
    input  wire logic                          i_room,
    output logic                               o_ready,
    output cvbe_pkg::t_push                    o_push
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
    localparam logic [COL_BITS-1:0] COL_ONE = COL_BITS'(1);

    logic                r_in_valid;
    logic [COL_BITS-1:0] r_col;
    logic                r_last;

    logic                r_open;
    logic [COL_BITS-1:0] r_start;
    logic [LEN_BITS-1:0] r_len;
    logic [COL_BITS-1:0] r_prior;

    logic                n_open;
    logic [COL_BITS-1:0] n_start;
    logic [LEN_BITS-1:0] n_len;

    logic                advance;
    logic [COL_BITS-1:0] delta;
    logic                emit_a;
    logic [COL_BITS-1:0] mid_start;
    logic [LEN_BITS-1:0] mid_len;
    cvbe_pkg::t_result   res_a;
    cvbe_pkg::t_result   res_b;

    function automatic logic [cvbe_pkg::START_OUT_W-1:0] START_OUT_W_CAST(
        input logic [COL_BITS-1:0] v
    );
        logic [COL_BITS+cvbe_pkg::START_OUT_W-1:0] w;
        w = {{cvbe_pkg::START_OUT_W{1'b0}}, v};
        return w[cvbe_pkg::START_OUT_W-1:0];
    endfunction

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_col  <= COL_BITS'(i_col);
            r_last <= i_last;
        end
    end

    // Consecutiveness is tested modulo 2^COL_BITS.
    assign delta = r_col - r_prior;

    always_comb begin
        emit_a    = 1'b0;
        mid_start = r_start;
        mid_len   = r_len;
        if (!r_open) begin
            mid_start = r_col;
            mid_len   = LEN_ONE;
        end else if (delta == COL_ONE) begin
            if (r_len == LEN_MAX) begin
                emit_a    = 1'b1;
                mid_start = r_col;
                mid_len   = LEN_ONE;
            end else begin
                mid_len = r_len + LEN_ONE;
            end
        end else if (delta != '0) begin
            emit_a    = 1'b1;
            mid_start = r_col;
            mid_len   = LEN_ONE;
        end

        // The end of a row closes whatever block is open after this column.
        n_open  = !r_last;
        n_start = r_last ? '0 : mid_start;
        n_len   = r_last ? '0 : mid_len;

        res_a.start     = START_OUT_W_CAST(r_start);
        res_a.len       = cvbe_pkg::LEN_OUT_W'(r_len);
        res_a.row_end   = 1'b0;
        res_a.step_last = !r_last;

        res_b.start     = START_OUT_W_CAST(mid_start);
        res_b.len       = cvbe_pkg::LEN_OUT_W'(mid_len);
        res_b.row_end   = 1'b1;
        res_b.step_last = 1'b1;

        o_push.n  = advance ? ({1'b0, emit_a} + {1'b0, r_last}) : 2'd0;
        o_push.r0 = emit_a ? res_a : res_b;
        o_push.r1 = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (advance) begin
            r_open <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_start <= n_start;
            r_len   <= n_len;
            r_prior <= r_col;
        end
    end

`ifndef ASSERT_OFF
    a_row_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> !r_open)
        else $error("block still open after the end of a row");

    a_two_needs_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.n == 2'd2 |-> (r_last && o_push.r1.row_end && !o_push.r0.row_end))
        else $error("two blocks from one item without a row end");

    a_open_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_len != '0))
        else $error("open block has zero length");
`endif

endmodule
`default_nettype wire

@@ rtl/cvbe_outq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cvbe_outq
// Small result queue that takes up to two blocks per cycle and presents one.
// ---------------------------------------------------------------------------
module cvbe_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cvbe_pkg::t_push   i_push,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cvbe_pkg::t_result      o_data
);

    cvbe_pkg::t_result               r_mem [cvbe_pkg::QDEPTH];
    logic [cvbe_pkg::QPTR_W-1:0]     r_wp;
    logic [cvbe_pkg::QPTR_W-1:0]     r_rp;
    logic [cvbe_pkg::QCNT_W-1:0]     r_count;
    logic [cvbe_pkg::QCNT_W-1:0]     n_count;
    logic [cvbe_pkg::QPTR_W-1:0]     wp_next;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // Room for the worst case of two blocks from the next item.
    assign o_room  = (r_count <= cvbe_pkg::QCNT_W'(cvbe_pkg::QDEPTH - 2));
    assign wp_next = r_wp + cvbe_pkg::QPTR_W'(1);
    assign n_count = r_count + cvbe_pkg::QCNT_W'(i_push.n)
                   - cvbe_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + cvbe_pkg::QPTR_W'(i_push.n);
            r_rp    <= r_rp + cvbe_pkg::QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp_next] <= i_push.r1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cvbe_pkg::QCNT_W'(cvbe_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> $past(o_room) || !$past(i_rst_n) || o_room
            || (r_count + cvbe_pkg::QCNT_W'(i_push.n)
                <= cvbe_pkg::QCNT_W'(cvbe_pkg::QDEPTH)))
        else $error("blocks pushed into a full queue");
`endif

endmodule
`default_nettype wire

@@ sim/csr_to_vbl_block_encoder_tb.sv @@
// ---------------------------------------------------------------------------
// csr_to_vbl_block_encoder_tb
// Streams sparse row column indices into the block encoder and checks every
// emitted start/length block against a cycle-free model of the run grouping.
// Directed rows cover the corners first, then long full-length runs and
// random rows, with bursty input and a stalling output side.
// ---------------------------------------------------------------------------
module csr_to_vbl_block_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cvbe_pkg::LEN_OUT_W-1:0] LEN_FULL =
        cvbe_pkg::LEN_OUT_W'((1 << cvbe_pkg::LEN_BITS_DEF) - 1);
    localparam logic [cvbe_pkg::LEN_OUT_W-1:0] LEN_ONE = cvbe_pkg::LEN_OUT_W'(1);
    localparam int RANDOM_ITEMS   = 360;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_SHOWN      = 10;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [cvbe_pkg::COL_IN_W-1:0]     i_s_tdata;   // [31:0] col_index
    logic                              i_s_tlast;   // row_last
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [cvbe_pkg::TDATA_OUT_W-1:0]  o_m_tdata;   // [31:0] block_start, [39:32] block_len
    logic                              o_m_tlast;   // row_end
    logic                              o_m_tuser;   // step_last

    // Model of the encoder's open block.
    logic                              run_open;
    logic [cvbe_pkg::COL_IN_W-1:0]     run_start;
    logic [cvbe_pkg::LEN_OUT_W-1:0]    run_len;
    logic [cvbe_pkg::COL_IN_W-1:0]     prev_col;

    cvbe_pkg::t_result       blocks_due[$];
    int                      mismatches  = 0;
    int                      cycle_count = 0;
    int                      burst_left  = 0;
    int                      ready_left  = 0;
    int                      ready_mode  = 0;

    csr_to_vbl_block_encoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Works out the blocks that one accepted column closes and queues them.
    task automatic predict_blocks(input logic [cvbe_pkg::COL_IN_W-1:0] col,
                                  input logic last);
        cvbe_pkg::t_result              closed[2];
        int                             n;
        logic [cvbe_pkg::COL_IN_W-1:0]  delta;
        n = 0;
        delta = col - prev_col;
        if (!run_open) begin
            run_open  = 1'b1;
            run_start = col;
            run_len   = LEN_ONE;
        end else if (delta == 1) begin
            if (run_len >= LEN_FULL) begin
                closed[n] = '{start: run_start, len: run_len, row_end: 1'b0, step_last: 1'b0};
                n++;
                run_start = col;
                run_len   = LEN_ONE;
            end else begin
                run_len++;
            end
        end else if (delta != 0) begin
            // A gap or a descending column closes the block.
            closed[n] = '{start: run_start, len: run_len, row_end: 1'b0, step_last: 1'b0};
            n++;
            run_start = col;
            run_len   = LEN_ONE;
        end
        prev_col = col;
        if (last) begin
            closed[n] = '{start: run_start, len: run_len, row_end: 1'b1, step_last: 1'b0};
            n++;
            run_open  = 1'b0;
            run_start = '0;
            run_len   = '0;
        end
        if (n > 0) closed[n-1].step_last = 1'b1;
        for (int i = 0; i < n; i++) blocks_due.push_back(closed[i]);
    endtask

    task automatic flag_mismatch(input string what, input cvbe_pkg::t_result want,
                                 input cvbe_pkg::t_result got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("mismatch (%s): expected start=%h len=%0d row_end=%b step_last=%b",
                     what, want.start, want.len, want.row_end, want.step_last);
            $display("                got      start=%h len=%0d row_end=%b step_last=%b",
                     got.start, got.len, got.row_end, got.step_last);
        end
    endtask

    // Sends one column word; the sender idles for a random gap between bursts.
    task automatic send_col(input logic [cvbe_pkg::COL_IN_W-1:0] col, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= $urandom;
                i_s_tlast  <= $urandom_range(0, 1);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= col;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_blocks(col, last);
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= $urandom;
        i_s_tlast  <= $urandom_range(0, 1);
        burst_left = 0;
    endtask

    // The receiver runs segments of random length, each with its own stall shape.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(4, 40);
        end
        ready_left--;
        case (ready_mode)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= $urandom_range(0, 1);
            end
            2: begin
                i_m_tready <= (ready_left % 4) != 0;
            end
            default: begin
                i_m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        cvbe_pkg::t_result got;
        cvbe_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{start: o_m_tdata[cvbe_pkg::START_OUT_W-1:0],
                    len: o_m_tdata[cvbe_pkg::TDATA_OUT_W-1:cvbe_pkg::START_OUT_W],
                    row_end: o_m_tlast, step_last: o_m_tuser};
            if (blocks_due.size() == 0) begin
                flag_mismatch("unexpected word", '0, got);
            end else begin
                want = blocks_due.pop_front();
                if (got !== want) flag_mismatch("wrong field", want, got);
            end
        end
    end

    task automatic test_single_rows();
        send_col('0, 1'b1);
        send_col('1, 1'b1);
        send_col(32'hA5A5_A5A5, 1'b1);
        hold_input();
    endtask

    task automatic test_consecutive_run();
        for (int c = 10; c <= 13; c++) send_col(c, c == 13);
        hold_input();
    endtask

    task automatic test_repeated_columns();
        send_col(20, 1'b0);
        send_col(20, 1'b0);
        send_col(21, 1'b0);
        send_col(21, 1'b1);
        // A repeat that carries the row end still closes the block.
        send_col(30, 1'b0);
        send_col(30, 1'b1);
        hold_input();
    endtask

    task automatic test_gaps_and_descent();
        send_col(40, 1'b0);
        send_col(41, 1'b0);
        send_col(45, 1'b0);
        send_col(44, 1'b0);
        // The gap and the row end close two blocks on one word.
        send_col(50, 1'b1);
        hold_input();
    endtask

    task automatic test_column_wrap();
        send_col(32'hFFFF_FFFE, 1'b0);
        send_col(32'hFFFF_FFFF, 1'b0);
        send_col(32'h0000_0000, 1'b1);
        hold_input();
    endtask

    task automatic test_full_blocks();
        logic [cvbe_pkg::COL_IN_W-1:0] base;
        base = $urandom;
        for (int i = 0; i < 260; i++) send_col(base + i, i == 259);
        // The full block closes on the same word as the row end.
        base = 32'hFFFF_FF80;
        for (int i = 0; i < 256; i++) send_col(base + i, i == 255);
        base = $urandom;
        for (int i = 0; i < 255; i++) send_col(base + i, i == 254);
        hold_input();
    endtask

    task automatic test_random_rows();
        int                            sent;
        int                            row_len;
        int                            pick;
        logic [cvbe_pkg::COL_IN_W-1:0] col;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            row_len = ($urandom_range(0, 29) == 0) ? $urandom_range(240, 300)
                                                   : $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0: col = $urandom;
                1: col = '1 - $urandom_range(0, 8);
                default: col = $urandom_range(0, 64);
            endcase
            for (int i = 0; i < row_len; i++) begin
                if (i > 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) col = col + 1;
                    else if (pick < 80) col = col;
                    else if (pick < 90) col = col + $urandom_range(2, 1000);
                    else if (pick < 95) col = col - $urandom_range(1, 50);
                    else col = $urandom;
                end
                send_col(col, i == row_len - 1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) hold_input();
        end
        hold_input();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        run_open   = 1'b0;
        run_start  = '0;
        run_len    = '0;
        prev_col   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_rows();
        test_consecutive_run();
        test_repeated_columns();
        test_gaps_and_descent();
        test_column_wrap();
        test_full_blocks();
        test_random_rows();

        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (blocks_due.size() != 0) begin
            mismatches += blocks_due.size();
            $display("%0d expected words never arrived", blocks_due.size());
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
